FILE: rtl/cce_pkg.sv
// shared types, constants and the polymod step for the checksum engine
// no dependencies
package cce_pkg;

    localparam int RES_W         = 40;
    localparam int SYM_W         = 5;
    localparam int IN_W          = 8;
    localparam int GEN_N         = 5;
    localparam int CHECK_SYMBOLS = 8;
    localparam int CNT_W         = $clog2(CHECK_SYMBOLS);

    localparam logic [RES_W-1:0] RES_ONE = RES_W'(1);

    localparam logic [RES_W-1:0] GEN [GEN_N] = '{
        40'h98f2bc8e61, 40'h79b76d99e2, 40'hf33e5fb3c4,
        40'hae2eabe2a8, 40'h1e4f43e470
    };

    // residue of a finished string handed to the finalizer
    typedef struct packed {
        logic             load;
        logic [RES_W-1:0] residue;
        logic             mode;
    } t_handoff;

    // one polymod step: shift in a 5-bit symbol, fold back the top symbol
    function automatic logic [RES_W-1:0] absorb(input logic [RES_W-1:0] res,
                                                input logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] top;
        logic [RES_W-1:0] r;
        top = res[RES_W-1 -: SYM_W];
        r   = {res[RES_W-SYM_W-1:0], sym};
        for (int k = 0; k < GEN_N; k++) begin
            if (top[k]) begin
                r = r ^ GEN[k];
            end
        end
        return r;
    endfunction

endpackage

FILE: rtl/cce_absorb.sv
// input register and per-item polymod update of the running residue
// depends on cce_pkg
module cce_absorb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cce_pkg::IN_W-1:0]   i_symbol,
    input  logic                       i_is_data,
    input  logic                       i_last,
    input  logic                       i_mode,
    input  logic                       i_fin_busy,
    output cce_pkg::t_handoff          o_handoff
);
    import cce_pkg::*;

    logic             r_in_valid;
    logic [SYM_W-1:0] r_sym;
    logic             r_is_data;
    logic             r_last;
    logic [RES_W-1:0] r_residue;
    logic             r_sep_done;

    logic             advance;
    logic             accept;
    logic [RES_W-1:0] n_a0;
    logic [RES_W-1:0] n_a1;
    logic [RES_W-1:0] n_a2;

    // a last item waits until the finalizer is free
    assign advance = r_in_valid && (!r_last || !i_fin_busy);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_a0 = (r_is_data && !r_sep_done) ? absorb(r_residue, '0) : r_residue;
        n_a1 = absorb(n_a0, r_sym);
        // separator at the end when no data came
        n_a2 = (!r_sep_done && !r_is_data) ? absorb(n_a1, '0) : n_a1;
    end

    assign o_handoff.load    = advance && r_last;
    assign o_handoff.residue = n_a2;
    assign o_handoff.mode    = i_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_residue  <= RES_ONE;
            r_sep_done <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                if (r_last) begin
                    r_residue  <= RES_ONE;
                    r_sep_done <= 1'b0;
                end else begin
                    r_residue  <= n_a1;
                    r_sep_done <= r_sep_done | r_is_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sym     <= i_symbol[SYM_W-1:0];
            r_is_data <= i_is_data;
            r_last    <= i_last;
        end
    end

endmodule

FILE: rtl/cce_final.sv
// finalizer: zero padding steps, checksum symbol shift-out or verify check, and result register
// depends on cce_pkg
module cce_final (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  cce_pkg::t_handoff          i_handoff,
    output logic                       o_busy,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cce_pkg::SYM_W-1:0]  o_check_symbol,
    output logic                       o_valid_res,
    output logic                       o_last_out
);
    import cce_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ZERO = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(CHECK_SYMBOLS - 1);

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [RES_W-1:0] r_mod;
    logic             r_verify;
    logic             r_out_valid;
    logic [SYM_W-1:0] r_check;
    logic             r_vres;
    logic             r_last_out;

    logic             out_free;
    logic             emit;
    logic             emit_last;

    assign out_free  = !r_out_valid || !i_stall;
    assign emit      = (r_state == S_EMIT) && out_free;
    assign emit_last = r_verify || (r_cnt == CNT_END);
    // free again in the cycle the final result of a string leaves
    assign o_busy    = (r_state != S_IDLE) && !(emit && emit_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_handoff.load) begin
                        r_cnt   <= '0;
                        r_state <= i_handoff.mode ? S_ZERO : S_EMIT;
                    end
                end
                S_ZERO: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_END) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (emit) begin
                        // a waiting last item loads as the final result leaves
                        if (emit_last && i_handoff.load) begin
                            r_cnt   <= '0;
                            r_state <= i_handoff.mode ? S_ZERO : S_EMIT;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                            if (emit_last) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_handoff.load) begin
            r_mod    <= i_handoff.residue;
            r_verify <= !i_handoff.mode;
        end else if (r_state == S_ZERO) begin
            if (r_cnt == CNT_END) begin
                r_mod <= absorb(r_mod, '0) ^ RES_ONE;
            end else begin
                r_mod <= absorb(r_mod, '0);
            end
        end else if (emit) begin
            r_mod <= {r_mod[RES_W-SYM_W-1:0], {SYM_W{1'b0}}};
        end
        if (emit) begin
            r_check    <= r_verify ? '0 : r_mod[RES_W-1 -: SYM_W];
            r_vres     <= r_verify ? (r_mod == RES_ONE) : 1'b1;
            r_last_out <= emit_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_check_symbol = r_check;
    assign o_valid_res    = r_vres;
    assign o_last_out     = r_last_out;

endmodule

FILE: rtl/cashaddr_checksum_engine.sv
// top level of the 40-bit polymod checksum engine: mode register and channel wiring
// depends on cce_pkg, cce_absorb, cce_final
//
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_symbol[7:0], i_is_data, i_last
// result    out        o_valid / i_stall      o_check_symbol[4:0], o_valid_res, o_last_out
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (mode)
//
// one item per cycle through the input register and the residue update when not stalled
// a last item hands its residue to the finalizer; verify gives one result, and
// create takes 8 padding steps and then 8 results, one per cycle when not stalled
// the next string streams in meanwhile; only its last item waits for the finalizer
// synchronous active-low reset: residue to one, separator flag and mode cleared
// output stall holds the result register, and the finalizer waits behind it
module cashaddr_checksum_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input items
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [cce_pkg::IN_W-1:0]   i_symbol,
    input  logic                       i_is_data,
    input  logic                       i_last,
    // result items
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [cce_pkg::SYM_W-1:0]  o_check_symbol,
    output logic                       o_valid_res,
    output logic                       o_last_out,
    // mode register write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic                       i_cfg_data
);
    import cce_pkg::*;

    logic     r_mode;
    logic     fin_busy;
    t_handoff handoff;

    // the mode register takes a write at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // per-item residue update, separator insertion
    cce_absorb u_absorb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_symbol   (i_symbol),
        .i_is_data  (i_is_data),
        .i_last     (i_last),
        .i_mode     (r_mode),
        .i_fin_busy (fin_busy),
        .o_handoff  (handoff)
    );

    // end-of-string handling and result register
    cce_final u_final (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_handoff      (handoff),
        .o_busy         (fin_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_check_symbol (o_check_symbol),
        .o_valid_res    (o_valid_res),
        .o_last_out     (o_last_out)
    );

endmodule
